// File: rtl/indexed_dary_min_heap_macros.svh
// Assertion helpers for the heap block
`ifndef INDEXED_DARY_MIN_HEAP_MACROS_SVH
`define INDEXED_DARY_MIN_HEAP_MACROS_SVH

`ifndef SYNTH
`define IDH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define IDH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IDH_ASSERT_IMP(lbl, ante, cons, msg)
`define IDH_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/idh_pkg.sv
package idh_pkg;
	localparam int CAPACITY_DEF  = 1024;
	localparam int MAX_ARITY_DEF = 8;
	localparam int VERTEX_W      = 10;
	localparam int KEY_W         = 31;
	localparam int NUM_VERTICES  = 1 << VERTEX_W;
	localparam int ARITY_W       = 4;
	localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;

	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_CHANGED   = 2'd1;
	localparam logic [1:0] ST_EXTRACTED = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	typedef struct packed {
		logic [VERTEX_W-1:0] vtx;
		logic [KEY_W-1:0]    key;
	} hp_entry_t;
endpackage

// File: rtl/indexed_dary_min_heap.sv
// channel   dir  tdata (low bit up)                  tuser
// s_axis    in   vertex[9:0], key[40:10], pad to 48  cmd
// m_axis    out  min_vertex[9:0], now_empty[10], pad  status
// cfg       in   arity[3:0] on cfg_we                 -
// Insert looks up the vertex in the position map: a vertex already held gets its key
// changed, a new one takes the next slot and is dropped on a full heap. It then sifts
// up one parent at a time; a parent whose key is not larger ends the sift. Extract
// takes the root and the last entry and sifts down level by level; extract on empty
// returns the empty status. After reset a pass over every vertex clears the position
// map; no word is taken then. A finished result sits in the output register; the next word is taken while it waits.
module indexed_dary_min_heap #(
	parameter int CAPACITY  = idh_pkg::CAPACITY_DEF,
	parameter int MAX_ARITY = idh_pkg::MAX_ARITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [47:0]                  s_axis_tdata,  // vertex, key
	input  logic                         s_axis_tuser,  // cmd
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [15:0]                  m_axis_tdata,  // min_vertex, now_empty
	output logic [1:0]                   m_axis_tuser,  // status
	input  logic                         cfg_we,
	input  logic [idh_pkg::ARITY_W-1:0]  cfg_wdata
);
	import idh_pkg::*;

	localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam int ARW  = $clog2(MAX_ARITY + 1);
	localparam int SH   = IDXW + ARW;
	localparam int PW   = IDXW + SH;
	localparam int CW   = IDXW + ARW + 1;
	localparam int AXW  = ARW + ARITY_W;
	localparam int PMW  = IDXW + 1;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_IN_LK, S_IN_DEC, S_EX_RD0, S_EX_RDL, S_EX_GOT,
		S_UP_CHK, S_UP_DIV, S_UP_RD, S_UP_CMP, S_DN_MUL, S_DN_RD, S_DN_CMP,
		S_DN_MOVE, S_PLACE, S_FIN
	} state_t;

	state_t state_q;

	logic [ARITY_W-1:0]  arity_q;
	logic [CNTW-1:0]     count_q;
	logic [IDXW-1:0]     hole_q;
	logic [IDXW-1:0]     parent_q;
	logic [PW-1:0]       prod_q;
	logic [CW-1:0]       c_q;
	logic [ARW-1:0]      i_q;
	logic                found_q;
	logic [IDXW-1:0]     best_idx_q;
	hp_entry_t           best_q;
	hp_entry_t           x_q;
	logic [VERTEX_W-1:0] minv_q;
	logic [1:0]          status_q;
	logic [VERTEX_W-1:0] clr_q;
	logic                m_valid_q;
	logic [15:0]         m_data_q;
	logic [1:0]          m_user_q;

	hp_entry_t           hp_mem [CAPACITY];
	logic [PMW-1:0]      pm_mem [NUM_VERTICES];
	hp_entry_t           hp_rd_q;
	logic [PMW-1:0]      pm_rd_q;

	logic                hp_we;
	logic [IDXW-1:0]     hp_wa;
	hp_entry_t           hp_wd;
	logic [IDXW-1:0]     hp_ra;
	logic                pm_we;
	logic [VERTEX_W-1:0] pm_wa;
	logic [PMW-1:0]      pm_wd;
	logic [VERTEX_W-1:0] pm_ra;

	logic [AXW-1:0]      a_ext;
	logic [ARW-1:0]      eff_d;
	logic [SH-1:0]       recip_w [2**ARW];
	logic [IDXW-1:0]     up_x;
	logic [IDXW-1:0]     q_est;
	logic [IDXW+ARW-1:0] q_rem;
	logic [IDXW-1:0]     q_fix;
	logic                up_less;
	logic                out_free;

	for (genvar g = 0; g < 2**ARW; g++) begin : g_recip
		if (g >= 2 && g <= MAX_ARITY) begin : g_on
			localparam logic [SH-1:0] RECIP = SH'((1 << SH) / g);
			assign recip_w[g] = RECIP;
		end else begin : g_off
			assign recip_w[g] = '0;
		end
	end

	assign a_ext = AXW'(arity_q);
	always_comb begin
		if (a_ext < AXW'(2))
			eff_d = ARW'(2);
		else if (a_ext > AXW'(MAX_ARITY))
			eff_d = ARW'(MAX_ARITY);
		else
			eff_d = ARW'(a_ext);
	end

	// parent = (hole-1)/d: reciprocal estimate, then one correction
	assign up_x  = hole_q - IDXW'(1);
	assign q_est = prod_q[PW-1:SH];
	assign q_rem = (IDXW+ARW)'(up_x) - (IDXW+ARW)'(q_est) * (IDXW+ARW)'(eff_d);
	assign q_fix = (q_rem >= (IDXW+ARW)'(eff_d)) ? q_est + IDXW'(1) : q_est;

	assign up_less  = x_q.key < hp_rd_q.key;
	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		hp_we = 1'b0;
		hp_wa = hole_q;
		hp_wd = x_q;
		hp_ra = '0;
		pm_we = 1'b0;
		pm_wa = x_q.vtx;
		pm_wd = {1'b1, hole_q};
		pm_ra = x_q.vtx;
		unique case (state_q)
			S_CLR: begin
				pm_we = 1'b1;
				pm_wa = clr_q;
				pm_wd = '0;
			end
			S_EX_RDL: begin
				hp_ra = IDXW'(count_q - CNTW'(1));
				pm_we = 1'b1;
				pm_wa = hp_rd_q.vtx;
				pm_wd = '0;
			end
			S_UP_RD: hp_ra = parent_q;
			S_UP_CMP: begin
				hp_we = up_less;
				hp_wd = hp_rd_q;
				pm_we = up_less;
				pm_wa = hp_rd_q.vtx;
			end
			S_DN_RD: hp_ra = c_q[IDXW-1:0];
			S_DN_MOVE: begin
				hp_we = 1'b1;
				hp_wd = best_q;
				pm_we = 1'b1;
				pm_wa = best_q.vtx;
			end
			S_PLACE: begin
				hp_we = 1'b1;
				pm_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hp_we)
			hp_mem[hp_wa] <= hp_wd;
		hp_rd_q <= hp_mem[hp_ra];
	end

	always_ff @(posedge clk) begin
		if (pm_we)
			pm_mem[pm_wa] <= pm_wd;
		pm_rd_q <= pm_mem[pm_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			arity_q    <= ARITY_RESET;
			count_q    <= '0;
			clr_q      <= '0;
			m_valid_q  <= 1'b0;
			hole_q     <= '0;
			parent_q   <= '0;
			prod_q     <= '0;
			c_q        <= '0;
			i_q        <= '0;
			found_q    <= 1'b0;
			best_idx_q <= '0;
			best_q     <= '0;
			x_q        <= '0;
			minv_q     <= '0;
			status_q   <= ST_INSERTED;
			m_data_q   <= '0;
			m_user_q   <= '0;
		end else begin
			if (cfg_we)
				arity_q <= cfg_wdata;
			if (state_q == S_FIN && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + VERTEX_W'(1);
					if (clr_q == VERTEX_W'(NUM_VERTICES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						x_q.vtx <= s_axis_tdata[VERTEX_W-1:0];
						x_q.key <= s_axis_tdata[VERTEX_W+KEY_W-1:VERTEX_W];
						minv_q  <= '0;
						if (s_axis_tuser == CMD_INSERT) begin
							state_q <= S_IN_LK;
						end else if (count_q == '0) begin
							status_q <= ST_EMPTY;
							state_q  <= S_FIN;
						end else begin
							status_q <= ST_EXTRACTED;
							state_q  <= S_EX_RD0;
						end
					end
				end
				S_IN_LK: state_q <= S_IN_DEC;
				S_IN_DEC: begin
					if (pm_rd_q[PMW-1]) begin
						status_q <= ST_CHANGED;
						if (CNTW'(pm_rd_q[IDXW-1:0]) < count_q) begin
							hole_q  <= pm_rd_q[IDXW-1:0];
							state_q <= S_UP_CHK;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						status_q <= ST_INSERTED;
						if (count_q < CNTW'(CAPACITY)) begin
							hole_q  <= IDXW'(count_q);
							count_q <= count_q + CNTW'(1);
							state_q <= S_UP_CHK;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_EX_RD0: state_q <= S_EX_RDL;
				S_EX_RDL: begin
					minv_q  <= hp_rd_q.vtx;
					state_q <= S_EX_GOT;
				end
				S_EX_GOT: begin
					x_q     <= hp_rd_q;
					hole_q  <= '0;
					count_q <= count_q - CNTW'(1);
					if (count_q == CNTW'(1))
						state_q <= S_FIN;
					else
						state_q <= S_DN_MUL;
				end
				S_UP_CHK: begin
					if (hole_q == '0) begin
						state_q <= S_PLACE;
					end else begin
						prod_q  <= PW'(up_x) * PW'(recip_w[eff_d]);
						state_q <= S_UP_DIV;
					end
				end
				S_UP_DIV: begin
					parent_q <= q_fix;
					state_q  <= S_UP_RD;
				end
				S_UP_RD: state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (up_less) begin
						hole_q  <= parent_q;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_DN_MUL: begin
					c_q     <= CW'(hole_q) * CW'(eff_d) + CW'(1);
					i_q     <= '0;
					found_q <= 1'b0;
					best_q  <= x_q;
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					if (i_q == eff_d || c_q >= CW'(count_q))
						state_q <= found_q ? S_DN_MOVE : S_PLACE;
					else
						state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (hp_rd_q.key < best_q.key) begin
						best_q     <= hp_rd_q;
						best_idx_q <= c_q[IDXW-1:0];
						found_q    <= 1'b1;
					end
					c_q     <= c_q + CW'(1);
					i_q     <= i_q + ARW'(1);
					state_q <= S_DN_RD;
				end
				S_DN_MOVE: begin
					hole_q  <= best_idx_q;
					state_q <= S_DN_MUL;
				end
				S_PLACE: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						m_user_q  <= status_q;
						m_data_q  <= {5'b0, (count_q == '0), minv_q};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	`include "indexed_dary_min_heap_macros.svh"

	`IDH_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CNTW'(CAPACITY), "count above capacity")
	`IDH_ASSERT_IMP(a_place_in_range, state_q == S_PLACE, CNTW'(hole_q) < count_q, "hole past end")
	`IDH_ASSERT_IMP(a_no_take_clr, state_q == S_CLR, !s_axis_tready, "word taken during clear")
	`IDH_ASSERT_NXT(a_fin_loads, state_q == S_FIN && out_free, m_valid_q && state_q == S_IDLE,
		"result not loaded")
	`IDH_ASSERT_IMP(a_child_range, state_q == S_DN_CMP, c_q < CW'(count_q), "child past end")
endmodule

// File: test/indexed_dary_min_heap_tb.sv
module indexed_dary_min_heap_tb;
	import idh_pkg::*;

	localparam int N_RANDOM = 900;
	localparam int WATCHDOG = 40000;
	localparam int SETTLE   = 200;

	typedef struct packed {
		logic [1:0]          status;
		logic [VERTEX_W-1:0] vtx;
		logic                empty;
	} heap_reply_t;

	typedef struct {
		logic                cmd;
		logic [VERTEX_W-1:0] vtx;
		logic [KEY_W-1:0]    key;
		logic                known;
		heap_reply_t         reply;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [ARITY_W-1:0] cfg_wdata = '0;

	always #4 clk = ~clk;

	indexed_dary_min_heap u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// heap shadow
	logic [VERTEX_W-1:0] hv [CAPACITY_DEF];
	logic [KEY_W-1:0]    hk [CAPACITY_DEF];
	int                  slot_of [NUM_VERTICES];
	bit                  in_heap [NUM_VERTICES];
	int                  fill;
	logic [ARITY_W-1:0]  arity_reg;

	heap_reply_t pending_replies [$];
	heap_reply_t typed_replies [$];
	bit          typed_valid [$];
	int mismatches = 0;
	int idle_cycles = 0;
	int send_idle = 0, recv_idle = 0;

	function automatic int fanout();
		if (arity_reg < 2) return 2;
		if (arity_reg > MAX_ARITY_DEF) return MAX_ARITY_DEF;
		return int'(arity_reg);
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [VERTEX_W-1:0] tv;
		logic [KEY_W-1:0] tk;
		tv = hv[a]; tk = hk[a];
		hv[a] = hv[b]; hk[a] = hk[b];
		hv[b] = tv; hk[b] = tk;
		slot_of[hv[a]] = a;
		slot_of[hv[b]] = b;
	endfunction

	function automatic void bubble_up(int s);
		int d, up;
		d = fanout();
		while (s > 0) begin
			up = (s - 1) / d;
			if (!(hk[s] < hk[up])) break;
			swap_slots(s, up);
			s = up;
		end
	endfunction

	function automatic void bubble_down(int s);
		int d, best, c;
		d = fanout();
		forever begin
			best = s;
			for (int i = 0; i < d; i++) begin
				c = s * d + i + 1;
				if (c < fill && hk[c] < hk[best]) best = c;
			end
			if (best == s) break;
			swap_slots(s, best);
			s = best;
		end
	endfunction

	function automatic heap_reply_t heap_apply(logic cmd, logic [VERTEX_W-1:0] v,
			logic [KEY_W-1:0] k);
		heap_reply_t r;
		int last;
		r = '0;
		if (cmd == CMD_INSERT) begin
			if (in_heap[v]) begin
				if (slot_of[v] < fill) begin
					hk[slot_of[v]] = k;
					bubble_up(slot_of[v]);
				end
				r.status = ST_CHANGED;
			end else begin
				r.status = ST_INSERTED;
				if (fill < CAPACITY_DEF) begin
					hv[fill] = v; hk[fill] = k;
					slot_of[v] = fill; in_heap[v] = 1;
					fill++;
					bubble_up(fill - 1);
				end
			end
		end else if (fill == 0) begin
			r.status = ST_EMPTY;
		end else begin
			last = fill - 1;
			r.vtx = hv[0];
			in_heap[hv[0]] = 0;
			slot_of[hv[0]] = 0;
			if (last > 0) begin
				hv[0] = hv[last]; hk[0] = hk[last];
				slot_of[hv[0]] = 0;
			end
			fill = last;
			bubble_down(0);
			r.status = ST_EXTRACTED;
		end
		r.empty = (fill == 0);
		return r;
	endfunction

	task automatic push_word(logic cmd, logic [VERTEX_W-1:0] v, logic [KEY_W-1:0] k,
			bit known = 0, heap_reply_t want = '0);
		heap_reply_t r;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {7'd0, k, v};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		r = heap_apply(cmd, v, k);
		pending_replies.push_back(r);
		typed_replies.push_back(want);
		typed_valid.push_back(known);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_arity(logic [ARITY_W-1:0] a);
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		arity_reg = a;
	endtask

	// receive side
	always @(posedge clk) begin
		heap_reply_t got, want, typed;
		bit known;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tuser;
				got.vtx = m_axis_tdata[9:0];
				got.empty = m_axis_tdata[10];
				if (pending_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %p", got);
				end else begin
					want = pending_replies.pop_front();
					typed = typed_replies.pop_front();
					known = typed_valid.pop_front();
					if (known && typed != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("typed row disagrees: typed %p computed %p", typed, want);
					end
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) $display("expected %p got %p", want, got);
					end
				end
			end
			m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("indexed_dary_min_heap regression: fail");
				$finish;
			end
		end
	end

	stim_row_t rows [] = '{
		'{CMD_EXTRACT, 10'd0,    31'd0,          1, '{ST_EMPTY, 10'd0, 1'b1}},
		'{CMD_INSERT,  10'd1023, 31'h7fffffff,   1, '{ST_INSERTED, 10'd0, 1'b0}},
		'{CMD_EXTRACT, 10'd0,    31'd0,          1, '{ST_EXTRACTED, 10'd1023, 1'b1}},
		'{CMD_INSERT,  10'd0,    31'd0,          1, '{ST_INSERTED, 10'd0, 1'b0}},
		'{CMD_INSERT,  10'd0,    31'h7fffffff,   1, '{ST_CHANGED, 10'd0, 1'b0}},
		'{CMD_INSERT,  10'd5,    31'd100,        0, '0},
		'{CMD_INSERT,  10'd6,    31'd50,         0, '0},
		'{CMD_INSERT,  10'd7,    31'd50,         0, '0},
		'{CMD_INSERT,  10'd8,    31'd10,         0, '0},
		'{CMD_INSERT,  10'd5,    31'd1,          0, '0},
		'{CMD_INSERT,  10'd6,    31'd200,        0, '0},
		'{CMD_INSERT,  10'h2aa,  31'h2aaaaaaa,   0, '0},
		'{CMD_INSERT,  10'h155,  31'h55555555,   0, '0},
		'{CMD_EXTRACT, 10'd0,    31'd0,          0, '0},
		'{CMD_EXTRACT, 10'd0,    31'd0,          0, '0},
		'{CMD_EXTRACT, 10'd0,    31'd0,          0, '0},
		'{CMD_EXTRACT, 10'd0,    31'd0,          0, '0},
		'{CMD_EXTRACT, 10'd0,    31'd0,          0, '0},
		'{CMD_EXTRACT, 10'd0,    31'd0,          0, '0},
		'{CMD_EXTRACT, 10'd0,    31'd0,          0, '0},
		'{CMD_EXTRACT, 10'd0,    31'd0,          0, '0},
		'{CMD_EXTRACT, 10'd0,    31'd0,          1, '{ST_EMPTY, 10'd0, 1'b1}}
	};

	logic [ARITY_W-1:0] arity_plan [] = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd5, 4'd2};

	task automatic random_phase(int count, bit fill_up);
		logic cmd;
		logic [VERTEX_W-1:0] v;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (fill_up) cmd = CMD_INSERT;
			else cmd = (pick < 40) ? CMD_EXTRACT : CMD_INSERT;
			if (fill == 0 && $urandom_range(3) != 0 && !fill_up) cmd = CMD_INSERT;
			v = VERTEX_W'($urandom_range(pick < 60 ? 63 : 1023));
			if (fill_up) v = n[VERTEX_W-1:0];
			push_word(cmd, v, KEY_W'((pick < 20) ? $urandom_range(15) : {$urandom} >> 1));
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_VERTICES; i++) begin
			in_heap[i] = 0;
			slot_of[i] = 0;
		end
		fill = 0;
		arity_reg = ARITY_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			push_word(rows[i].cmd, rows[i].vtx, rows[i].key, rows[i].known, rows[i].reply);
		drain();

		// fill to capacity at full arity, then a key change on the full heap
		set_arity(4'd8);
		recv_idle = 0; send_idle = 0;
		random_phase(CAPACITY_DEF, 1);
		push_word(CMD_INSERT, 10'd0, 31'd3);
		drain();

		foreach (arity_plan[p]) begin
			set_arity(arity_plan[p]);
			if (p < 2) begin send_idle = 24; recv_idle = 82; end
			else if (p < 4) begin send_idle = 82; recv_idle = 24; end
			else begin send_idle = 0; recv_idle = 0; end
			random_phase(N_RANDOM / arity_plan.size(), 0);
			drain();
		end

		if (mismatches == 0)
			$display("indexed_dary_min_heap regression: pass");
		else
			$display("indexed_dary_min_heap regression: fail");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/idh_pkg.sv
rtl/indexed_dary_min_heap.sv
test/indexed_dary_min_heap_tb.sv
